// File: design/lspa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lifetime slot pool allocator package
// Shared payload types, controller state, broadcast controls and constants.
// ----------------------------------------------------------------------------
package lspa_pkg;

  // Field widths fixed by the transaction format.
  localparam int OP_W    = 1;
  localparam int LIFE_W  = 16;
  localparam int SLOT_W  = 6;
  localparam int LCNT_W  = 7;
  localparam int CAP_W   = 7;

  // Configuration port geometry.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register indexes, taken from the word address.
  localparam logic [PADDR_W-3:0] REG_LIVE_CAP = '0;

  // Reset value of the live cap register.
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_SPAWN = 1'b0;
  localparam logic [OP_W-1:0] OP_TICK  = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [LIFE_W-1:0] life_ticks;
    logic [LIFE_W-1:0] tick_amount;
  } item_t;

  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] slot;
    logic              replaced_live;
    logic [LCNT_W-1:0] live_count;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COUNT
  } state_t;

  // Controls broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic spawn;      // a spawn token is walking the ring
    logic overwrite;  // the token has gone full circle: take the slot it sits on
    logic ring_close; // feed the last cell's token back into the first cell
    logic tick;       // age every live slot this cycle
  } ctrl_t;

endpackage

// File: design/lspa_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slot cell
// Holds one slot (live bit, age, lifetime) and one stage of the token ring.
// ----------------------------------------------------------------------------
module lspa_cell #(
  parameter int AGE_BITS = 16,
  parameter int CNT_W    = 7,
  parameter int IDX_W    = 6,
  parameter int IDX      = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  lspa_pkg::ctrl_t        ctrl,
  input  logic                   inject,
  input  logic [IDX_W-1:0]       inject_idx,
  input  logic [AGE_BITS-1:0]    life_in,
  input  logic [lspa_pkg::LIFE_W-1:0] amount,
  input  logic                   tok_in_vld,
  input  logic [CNT_W-1:0]       tok_in_cnt,
  output logic                   tok_out_vld,
  output logic [CNT_W-1:0]       tok_out_cnt,
  output logic                   claim,
  output logic                   claim_live,
  output logic                   tok_held
);
  import lspa_pkg::*;

  localparam int SUM_W = ((AGE_BITS > LIFE_W) ? AGE_BITS : LIFE_W) + 1;
  localparam logic [SUM_W-1:0] AGE_MAX = {{(SUM_W-AGE_BITS){1'b0}}, {AGE_BITS{1'b1}}};

  logic                live;
  logic [AGE_BITS-1:0] age;
  logic [AGE_BITS-1:0] life;
  logic                tok_vld;
  logic [CNT_W-1:0]    tok_cnt;

  logic                inject_hit;
  logic [SUM_W-1:0]    age_sum;
  logic [AGE_BITS-1:0] age_sat;

  // A spawn token stops here when it finds a free slot, or when it has gone round.
  assign inject_hit  = inject && (inject_idx == IDX_W'(IDX));
  assign claim       = tok_vld && ctrl.spawn && (!live || ctrl.overwrite);
  assign claim_live  = claim && live;
  assign tok_held    = tok_vld;

  // A passing token also accumulates the live count of the cells it visits.
  assign tok_out_vld = tok_vld && !claim;
  assign tok_out_cnt = tok_cnt + CNT_W'(live);

  // Saturating age update for a tick.
  always_comb begin
    age_sum = SUM_W'(age) + SUM_W'(amount);
    age_sat = (age_sum > AGE_MAX) ? AGE_MAX[AGE_BITS-1:0] : age_sum[AGE_BITS-1:0];
  end

  // Control state: live bit and token presence.
  always_ff @(posedge clk) begin
    if (rst) begin
      live    <= 1'b0;
      tok_vld <= 1'b0;
    end else begin
      tok_vld <= inject_hit || tok_in_vld;
      if (claim) begin
        live <= 1'b1;
      end else if (ctrl.tick && live && (age_sat >= life)) begin
        live <= 1'b0;
      end
    end
  end

  // Slot payload and token count.
  always_ff @(posedge clk) begin
    tok_cnt <= inject_hit ? '0 : tok_in_cnt;
    if (claim) begin
      age  <= '0;
      life <= life_in;
    end else if (ctrl.tick && live) begin
      age <= age_sat;
    end
  end

endmodule

// File: design/lspa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pool sequencer
// Accepts transactions, launches tokens into the cell ring, collects results.
// ----------------------------------------------------------------------------
module lspa_ctrl #(
  parameter int SLOTS    = 64,
  parameter int AGE_BITS = 16,
  parameter int IDX_W    = 6,
  parameter int CNT_W    = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  lspa_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_stall,
  output lspa_pkg::result_t          result,
  input  logic [lspa_pkg::CAP_W-1:0] live_cap,
  output lspa_pkg::ctrl_t            bcast,
  output logic                       inject,
  output logic [IDX_W-1:0]           inject_idx,
  output logic [AGE_BITS-1:0]        life,
  input  logic                       claim_any,
  input  logic                       claim_live,
  input  logic                       cnt_vld,
  input  logic [CNT_W-1:0]           cnt_val
);
  import lspa_pkg::*;

  localparam int STEP_W = $clog2(SLOTS + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int SUM_W  = ((AGE_BITS > LIFE_W) ? AGE_BITS : LIFE_W) + 1;
  localparam logic [SUM_W-1:0] AGE_MAX = {{(SUM_W-AGE_BITS){1'b0}}, {AGE_BITS{1'b1}}};

  state_t              state, state_next;
  logic [IDX_W-1:0]    cursor, cursor_next;
  logic [IDX_W-1:0]    pos, pos_next;
  logic [STEP_W-1:0]   steps, steps_next;
  logic [CNT_W-1:0]    live_total, live_total_next;
  logic [AGE_BITS-1:0] life_next;
  result_t             res_hold, res_hold_next;
  logic                res_full, res_full_next;
  logic                result_valid_next;
  result_t             result_next;

  logic                accept;
  logic                is_spawn;
  logic                below_cap;
  logic [SUM_W-1:0]    life_ext;
  logic [IDX_W-1:0]    pos_wrap;
  logic [CNT_W-1:0]    total_grant;

  assign item_stall  = (state != ST_IDLE) || res_full;
  assign accept      = item_valid && !item_stall;
  assign is_spawn    = (item.op == OP_SPAWN);
  assign below_cap   = CMP_W'(live_total) < CMP_W'(live_cap);
  assign life_ext    = SUM_W'(item.life_ticks);
  assign pos_wrap    = (pos == IDX_W'(SLOTS - 1)) ? '0 : pos + 1'b1;
  assign total_grant = live_total + CNT_W'(!claim_live);

  // Broadcast controls and token injection.
  always_comb begin
    bcast.spawn      = (state == ST_SCAN);
    bcast.overwrite  = (steps == STEP_W'(SLOTS));
    bcast.ring_close = (state == ST_SCAN);
    bcast.tick       = accept && !is_spawn;
    inject           = accept && (!is_spawn || below_cap);
    inject_idx       = is_spawn ? cursor : '0;
  end

  // Next state, result capture and output register hand-over.
  always_comb begin
    state_next        = state;
    cursor_next       = cursor;
    pos_next          = pos;
    steps_next        = steps;
    live_total_next   = live_total;
    life_next         = life;
    res_hold_next     = res_hold;
    res_full_next     = res_full;
    result_valid_next = result_valid;
    result_next       = result;

    // Move a finished result into the output register when it is free.
    if (res_full && (!result_valid || !result_stall)) begin
      result_next       = res_hold;
      result_valid_next = 1'b1;
      res_full_next     = 1'b0;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (is_spawn && below_cap) begin
            state_next = ST_SCAN;
            pos_next   = cursor;
            steps_next = '0;
            life_next  = (life_ext > AGE_MAX) ? AGE_MAX[AGE_BITS-1:0]
                                              : life_ext[AGE_BITS-1:0];
          end else if (is_spawn) begin
            // Refused spawn: nothing changes.
            res_hold_next.granted       = 1'b0;
            res_hold_next.slot          = '0;
            res_hold_next.replaced_live = 1'b0;
            res_hold_next.live_count    = LCNT_W'(live_total);
            res_full_next               = 1'b1;
          end else begin
            state_next = ST_COUNT;
          end
        end
      end
      ST_SCAN: begin
        if (claim_any) begin
          live_total_next             = total_grant;
          cursor_next                 = pos_wrap;
          res_hold_next.granted       = 1'b1;
          res_hold_next.slot          = SLOT_W'(pos);
          res_hold_next.replaced_live = claim_live;
          res_hold_next.live_count    = LCNT_W'(total_grant);
          res_full_next               = 1'b1;
          state_next                  = ST_IDLE;
        end else begin
          pos_next   = pos_wrap;
          steps_next = steps + 1'b1;
        end
      end
      ST_COUNT: begin
        if (cnt_vld) begin
          live_total_next             = cnt_val;
          res_hold_next.granted       = 1'b0;
          res_hold_next.slot          = '0;
          res_hold_next.replaced_live = 1'b0;
          res_hold_next.live_count    = LCNT_W'(cnt_val);
          res_full_next               = 1'b1;
          state_next                  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cursor       <= '0;
      pos          <= '0;
      steps        <= '0;
      live_total   <= '0;
      res_full     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cursor       <= cursor_next;
      pos          <= pos_next;
      steps        <= steps_next;
      live_total   <= live_total_next;
      res_full     <= res_full_next;
      result_valid <= result_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    life     <= life_next;
    res_hold <= res_hold_next;
    result   <= result_next;
  end

endmodule

// File: design/lifetime_slot_pool_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lifetime slot pool allocator
// Throughput: one transaction at a time, taken once the result leaves the holding
// stage. From accept to result valid, a refused spawn passes the holding and output
// registers; a granted spawn waits for its token to claim a slot and a tick for its
// token to reach the last cell, the token stepping one cell per cycle round the ring.
// Reset (synchronous): all slots free, cursor and live count zero, live cap 64.
// ----------------------------------------------------------------------------
module lifetime_slot_pool_allocator_top #(
  parameter int SLOTS    = 64,
  parameter int AGE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  lspa_pkg::item_t              item,
  output logic                         result_valid,
  input  logic                         result_stall,
  output lspa_pkg::result_t            result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lspa_pkg::PADDR_W-1:0] paddr,
  input  logic [lspa_pkg::PDATA_W-1:0] pwdata,
  output logic [lspa_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import lspa_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);

  logic [CAP_W-1:0]    live_cap;
  logic                cfg_write;

  ctrl_t               bcast;
  logic                inject;
  logic [IDX_W-1:0]    inject_idx;
  logic [AGE_BITS-1:0] life;

  logic [SLOTS-1:0]    in_vld;
  logic [CNT_W-1:0]    in_cnt  [SLOTS];
  logic [SLOTS-1:0]    out_vld;
  logic [CNT_W-1:0]    out_cnt [SLOTS];
  logic [SLOTS-1:0]    claim;
  logic [SLOTS-1:0]    claim_live;
  logic [SLOTS-1:0]    tok_held;

  // Configuration port: single live cap register, always ready.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_LIVE_CAP);
  assign prdata    = (paddr[PADDR_W-1:2] == REG_LIVE_CAP) ? PDATA_W'(live_cap) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_cap <= CAP_RESET;
    end else if (cfg_write) begin
      live_cap <= pwdata[CAP_W-1:0];
    end
  end

  // Sequencer.
  lspa_ctrl #(
    .SLOTS    (SLOTS),
    .AGE_BITS (AGE_BITS),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .live_cap     (live_cap),
    .bcast        (bcast),
    .inject       (inject),
    .inject_idx   (inject_idx),
    .life         (life),
    .claim_any    (|claim),
    .claim_live   (|claim_live),
    .cnt_vld      (out_vld[SLOTS-1]),
    .cnt_val      (out_cnt[SLOTS-1])
  );

  // Ring of slot cells; the last cell feeds the first while a spawn walks.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign in_vld[g] = out_vld[SLOTS-1] && bcast.ring_close;
      assign in_cnt[g] = out_cnt[SLOTS-1];
    end else begin : g_body
      assign in_vld[g] = out_vld[g-1];
      assign in_cnt[g] = out_cnt[g-1];
    end

    lspa_cell #(
      .AGE_BITS (AGE_BITS),
      .CNT_W    (CNT_W),
      .IDX_W    (IDX_W),
      .IDX      (g)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (bcast),
      .inject      (inject),
      .inject_idx  (inject_idx),
      .life_in     (life),
      .amount      (item.tick_amount),
      .tok_in_vld  (in_vld[g]),
      .tok_in_cnt  (in_cnt[g]),
      .tok_out_vld (out_vld[g]),
      .tok_out_cnt (out_cnt[g]),
      .claim       (claim[g]),
      .claim_live  (claim_live[g]),
      .tok_held    (tok_held[g])
    );
  end

  // At most one token is ever in flight round the ring.
  a_single_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_held) <= 1)
    else $error("more than one token in the cell ring");

  // An accepted tick starts its counting token at the first cell.
  a_tick_token: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && (item.op == OP_TICK)) |=> tok_held[0])
    else $error("tick did not launch a counting token at the first cell");

  // An overwrite is only ever reported on a granted spawn.
  a_replace_grant: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.replaced_live) |-> result.granted)
    else $error("replaced slot reported without a grant");

endmodule
